@@ rtl/core/ltv_pkg.sv @@
// Shared types and constants for the two-axis Langevin velocity-Verlet stepper.
// No dependencies; every other file in rtl/core imports this package.
package ltv_pkg;

   localparam int WORD_W     = 32;
   localparam int NOISE_W    = 16;
   localparam int INTERVAL_W = 16;
   localparam int LIMIT_W    = 31;
   localparam int CSR_IDX_W  = 3;

   // Remainder unit retires two dividend bits per cycle
   localparam int REM_STEPS = WORD_W / 2;
   localparam int REM_CNT_W = $clog2(REM_STEPS);

   // Reset values of the configuration registers
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1;
   localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 31'd65536;
   localparam logic [WORD_W-1:0]     STEP_RESET     = 32'd1;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STIFFNESS_X  = 3'd0,
      CSR_STIFFNESS_Y  = 3'd1,
      CSR_DAMPING_RATE = 3'd2,
      CSR_NOISE_GAIN   = 3'd3,
      CSR_TIME_STEP    = 3'd4,
      CSR_SAVE_INTVL   = 3'd5,
      CSR_LOSS_LIMIT   = 3'd6
   } csr_index_type;

   // Input word: one pair of Q4.12 normal deviates
   typedef struct packed {
      logic signed [NOISE_W-1:0] noise_x;
      logic signed [NOISE_W-1:0] noise_y;
   } req_word_type;

   // Result word: reported state, Q16.16
   typedef struct packed {
      logic        [WORD_W-1:0] step_number;
      logic signed [WORD_W-1:0] position_x;
      logic signed [WORD_W-1:0] position_y;
      logic signed [WORD_W-1:0] velocity_x;
      logic signed [WORD_W-1:0] velocity_y;
      logic                     lost;
   } rsp_word_type;

   // Per-lane coefficients, all unsigned Q16.16
   typedef struct packed {
      logic [WORD_W-1:0] stiffness;
      logic [WORD_W-1:0] damping;
      logic [WORD_W-1:0] gain;
      logic [WORD_W-1:0] dt;
   } lane_cfg_type;

   // Lane status back to the merge stage
   typedef struct packed {
      logic                     busy;
      logic signed [WORD_W-1:0] pos;
      logic signed [WORD_W-1:0] vel;
   } lane_status_type;

endpackage

@@ rtl/core/ltv_lane.sv @@
// One axis of the integrator: a shared 32x32 multiplier sequenced through the
// eight products of a velocity-Verlet step. Depends on ltv_pkg.
module ltv_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  ltv_pkg::lane_cfg_type         cfg,
   input  logic signed [ltv_pkg::NOISE_W-1:0] noise,
   output ltv_pkg::lane_status_type      status
);
   import ltv_pkg::*;

   localparam int PROD_W = 2 * WORD_W;
   localparam int SHR_W  = PROD_W + 1 - 12;  // widest shifted magnitude
   localparam int TERM_W = SHR_W + 1;
   localparam int SUM_W  = TERM_W + 2;

   localparam logic [PROD_W:0] HALF_12 = (PROD_W+1)'(1) << 11;
   localparam logic [PROD_W:0] HALF_16 = (PROD_W+1)'(1) << 15;
   localparam logic [PROD_W:0] HALF_17 = (PROD_W+1)'(1) << 16;

   typedef enum logic [1:0] {ST_IDLE, ST_OPND, ST_MULT, ST_ACC} state_type;
   typedef enum logic [2:0] {
      OP_FORCE, OP_KP1, OP_GV1, OP_DV1, OP_DP, OP_KP2, OP_GV2, OP_DV2
   } op_type;

   state_type                 state_ff;
   op_type                    op_ff;
   logic signed [NOISE_W-1:0] noise_ff;
   logic signed [WORD_W-1:0]  pos_ff, vel_ff, force_ff, acc_ff;
   logic signed [TERM_W-1:0]  kp_ff;
   logic        [WORD_W-1:0]  mag_ff, mul_u_ff;
   logic                      neg_ff;
   logic        [PROD_W-1:0]  prod_ff;

   logic signed [WORD_W-1:0]  opnd_s;
   logic        [WORD_W-1:0]  opnd_u, mag_in;
   logic        [PROD_W-1:0]  prod_in;
   logic        [PROD_W:0]    half, rnd;
   logic        [SHR_W-1:0]   mag_sh;
   logic signed [TERM_W-1:0]  term;
   logic signed [SUM_W-1:0]   term_x, acc_sum, vel_sum, pos_sum;

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi, lo;
      hi = SUM_W'(32'sh7FFF_FFFF);
      lo = -hi - SUM_W'(1);
      if (v > hi) return WORD_W'(hi);
      else if (v < lo) return WORD_W'(lo);
      else return v[WORD_W-1:0];
   endfunction

   // Operand select for the current product
   always_comb begin
      case (op_ff)
         OP_FORCE: begin
            opnd_s = {{(WORD_W-NOISE_W){noise_ff[NOISE_W-1]}}, noise_ff};
            opnd_u = cfg.gain;
         end
         OP_KP1, OP_KP2: begin
            opnd_s = pos_ff;
            opnd_u = cfg.stiffness;
         end
         OP_GV1, OP_GV2: begin
            opnd_s = vel_ff;
            opnd_u = cfg.damping;
         end
         OP_DV1, OP_DV2: begin
            opnd_s = acc_ff;
            opnd_u = cfg.dt;
         end
         OP_DP: begin
            opnd_s = vel_ff;
            opnd_u = cfg.dt;
         end
         default: begin
            opnd_s = '0;
            opnd_u = '0;
         end
      endcase
      mag_in  = opnd_s[WORD_W-1] ? WORD_W'(-opnd_s) : opnd_s;
      prod_in = PROD_W'(mag_ff) * PROD_W'(mul_u_ff);
   end

   // Rounding shift, half away from zero on the magnitude, then sign
   always_comb begin
      case (op_ff)
         OP_FORCE:       half = HALF_12;
         OP_DV1, OP_DV2: half = HALF_17;
         default:        half = HALF_16;
      endcase
      rnd = {1'b0, prod_ff} + half;
      case (op_ff)
         OP_FORCE:       mag_sh = rnd[PROD_W:12];
         OP_DV1, OP_DV2: mag_sh = {5'b0, rnd[PROD_W:17]};
         default:        mag_sh = {4'b0, rnd[PROD_W:16]};
      endcase
      term    = neg_ff ? -$signed({1'b0, mag_sh}) : $signed({1'b0, mag_sh});
      term_x  = {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};
      acc_sum = $signed({{(SUM_W-WORD_W){force_ff[WORD_W-1]}}, force_ff})
              - $signed({{(SUM_W-TERM_W){kp_ff[TERM_W-1]}}, kp_ff}) - term_x;
      vel_sum = $signed({{(SUM_W-WORD_W){vel_ff[WORD_W-1]}}, vel_ff}) + term_x;
      pos_sum = $signed({{(SUM_W-WORD_W){pos_ff[WORD_W-1]}}, pos_ff}) + term_x;
   end

   // Sequencer: operand, multiply, accumulate for each of the eight products
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_FORCE;
         pos_ff   <= '0;
         vel_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  noise_ff <= noise;
                  op_ff    <= OP_FORCE;
                  state_ff <= ST_OPND;
               end
            end
            ST_OPND: begin
               mag_ff   <= mag_in;
               mul_u_ff <= opnd_u;
               neg_ff   <= opnd_s[WORD_W-1];
               state_ff <= ST_MULT;
            end
            ST_MULT: begin
               prod_ff  <= prod_in;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               case (op_ff)
                  OP_FORCE:       force_ff <= sat32(term_x);
                  OP_KP1, OP_KP2: kp_ff    <= term;
                  OP_GV1, OP_GV2: acc_ff   <= sat32(acc_sum);
                  OP_DV1, OP_DV2: vel_ff   <= sat32(vel_sum);
                  OP_DP:          pos_ff   <= sat32(pos_sum);
                  default:        ;
               endcase
               if (op_ff == OP_DV2) begin
                  state_ff <= ST_IDLE;
               end else begin
                  op_ff    <= op_type'(op_ff + 3'd1);
                  state_ff <= ST_OPND;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign status.busy = (state_ff != ST_IDLE);
   assign status.pos  = pos_ff;
   assign status.vel  = vel_ff;

endmodule

@@ rtl/core/ltv_rem.sv @@
// Step counter modulo the save interval, restoring division two bits a cycle.
// Depends on ltv_pkg.
module ltv_rem (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ltv_pkg::WORD_W-1:0]        dividend,
   input  logic [ltv_pkg::INTERVAL_W-1:0]    divisor,
   output logic                              busy,
   output logic                              rem_zero
);
   import ltv_pkg::*;

   logic                  busy_ff;
   logic [REM_CNT_W-1:0]  cnt_ff;
   logic [WORD_W-1:0]     dvd_ff;
   logic [INTERVAL_W-1:0] rem_ff, div_ff;

   logic [INTERVAL_W:0]   t1, t2;
   logic [INTERVAL_W-1:0] r1, r2;

   // Two restoring steps per cycle; the remainder always stays below div_ff
   always_comb begin
      t1 = {rem_ff, dvd_ff[WORD_W-1]};
      r1 = (t1 >= {1'b0, div_ff}) ? INTERVAL_W'(t1 - {1'b0, div_ff}) : t1[INTERVAL_W-1:0];
      t2 = {r1, dvd_ff[WORD_W-2]};
      r2 = (t2 >= {1'b0, div_ff}) ? INTERVAL_W'(t2 - {1'b0, div_ff}) : t2[INTERVAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         dvd_ff  <= dividend;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff <= r2;
         dvd_ff <= {dvd_ff[WORD_W-3:0], 2'b00};
         cnt_ff <= cnt_ff + REM_CNT_W'(1);
         if (cnt_ff == REM_CNT_W'(REM_STEPS - 1)) busy_ff <= 1'b0;
      end
   end

   assign busy     = busy_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

@@ rtl/core/langevin_two_axis_verlet_step.sv @@
// Top level of the two-axis Langevin velocity-Verlet stepper: configuration,
// two axis lanes, the interval remainder unit and the merge/report stage.
//
//   channel | ports                         | word
//   --------+-------------------------------+-------------------------------
//   input   | req_valid, req_stall, req_data | noise_x, noise_y (Q4.12)
//   result  | rsp_valid, rsp_stall, rsp_data | step, pos x/y, vel x/y, lost
//   config  | csr_wr_en, csr_index, csr_wdata| seven registers, write only
//
// Each word passes accept, then eight products in each lane, each through operand,
// multiply and accumulate on the lane's one multiplier, then one merge.
// The remainder unit runs beside the lanes.
// A finished result sits in the output register; the next word is taken meanwhile.
// The merge stage waits only if a result is due while the previous one is stalled.
// After a lost word, input words are taken and dropped until reset.
// Reset is synchronous; control, configuration, positions, velocities and step reset.
module langevin_two_axis_verlet_step (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ltv_pkg::req_word_type            req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ltv_pkg::rsp_word_type            rsp_data,
   input  logic                             csr_wr_en,
   input  logic [ltv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ltv_pkg::WORD_W-1:0]       csr_wdata
);
   import ltv_pkg::*;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   // Configuration registers
   logic [WORD_W-1:0]     stiffness_x_ff, stiffness_y_ff, damping_ff, gain_ff, dt_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [LIMIT_W-1:0]    limit_ff;

   // Control and result registers
   state_type         state_ff;
   logic              halted_ff;
   logic [WORD_W-1:0] step_ff;
   logic              rsp_valid_ff;
   rsp_word_type      rsp_data_ff;

   logic              req_accept, start, units_done, out_free, lost, report, step_done;
   logic [WORD_W-1:0] abs_x;
   logic [INTERVAL_W-1:0] interval;
   lane_cfg_type      cfg_x, cfg_y;
   lane_status_type   lane_x, lane_y;
   logic              rem_busy, rem_zero;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         stiffness_x_ff <= '0;
         stiffness_y_ff <= '0;
         damping_ff     <= '0;
         gain_ff        <= '0;
         dt_ff          <= '0;
         interval_ff    <= INTERVAL_RESET;
         limit_ff       <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_STIFFNESS_X:  stiffness_x_ff <= csr_wdata;
            CSR_STIFFNESS_Y:  stiffness_y_ff <= csr_wdata;
            CSR_DAMPING_RATE: damping_ff     <= csr_wdata;
            CSR_NOISE_GAIN:   gain_ff        <= csr_wdata;
            CSR_TIME_STEP:    dt_ff          <= csr_wdata;
            CSR_SAVE_INTVL:   interval_ff    <= csr_wdata[INTERVAL_W-1:0];
            CSR_LOSS_LIMIT:   limit_ff       <= csr_wdata[LIMIT_W-1:0];
            default:          ;
         endcase
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign start      = req_accept && !halted_ff;
   assign interval   = (interval_ff == '0) ? INTERVAL_W'(1) : interval_ff;

   assign cfg_x = '{stiffness: stiffness_x_ff, damping: damping_ff, gain: gain_ff, dt: dt_ff};
   assign cfg_y = '{stiffness: stiffness_y_ff, damping: damping_ff, gain: gain_ff, dt: dt_ff};

   // Axis lanes
   ltv_lane u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cfg    (cfg_x),
      .noise  (req_data.noise_x),
      .status (lane_x)
   );

   ltv_lane u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cfg    (cfg_y),
      .noise  (req_data.noise_y),
      .status (lane_y)
   );

   // Report-interval check
   ltv_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend (step_ff),
      .divisor  (interval),
      .busy     (rem_busy),
      .rem_zero (rem_zero)
   );

   // Merge: loss test and report decision
   always_comb begin
      units_done = !lane_x.busy && !lane_y.busy && !rem_busy;
      abs_x      = lane_x.pos[WORD_W-1] ? WORD_W'(-lane_x.pos) : lane_x.pos;
      lost       = abs_x > {1'b0, limit_ff};
      report     = lost || rem_zero;
      out_free   = !rsp_valid_ff || !rsp_stall;
      step_done  = (state_ff == ST_RUN) && units_done && (!report || out_free);
   end

   // Control and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         halted_ff    <= 1'b0;
         step_ff      <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) state_ff <= ST_RUN;
            end
            ST_RUN: begin
               if (step_done) begin
                  state_ff  <= ST_IDLE;
                  halted_ff <= lost;
                  step_ff   <= step_ff + WORD_W'(1);
                  if (report) begin
                     rsp_data_ff.step_number <= step_ff;
                     rsp_data_ff.position_x  <= lane_x.pos;
                     rsp_data_ff.position_y  <= lane_y.pos;
                     rsp_data_ff.velocity_x  <= lane_x.vel;
                     rsp_data_ff.velocity_y  <= lane_y.vel;
                     rsp_data_ff.lost        <= lost;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         // Result valid: set by a due report, cleared once the word is taken
         if (step_done && report) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/ltv_check.sv @@
// Port-level checker for the Langevin stepper, bound to the top level.
// Depends on ltv_pkg and langevin_two_axis_verlet_step.
module ltv_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input ltv_pkg::rsp_word_type         rsp_data
);
   import ltv_pkg::*;

   logic lost_shown_ff, lost_taken_ff;
   logic req_accept, rsp_accept, halting;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign halting    = lost_shown_ff || (rsp_valid && rsp_data.lost);

   // Track whether a lost word has been offered and taken
   always_ff @(posedge clock) begin
      if (reset) begin
         lost_shown_ff <= 1'b0;
         lost_taken_ff <= 1'b0;
      end else begin
         if (rsp_valid && rsp_data.lost) lost_shown_ff <= 1'b1;
         if (rsp_accept && rsp_data.lost) lost_taken_ff <= 1'b1;
      end
   end

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Nothing is reported after the lost word is taken
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      lost_taken_ff |-> !rsp_valid)
      else $error("result after halt");

   // A running block is busy after it takes a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept && !halting |=> req_stall)
      else $error("input not stalled while a step is in work");

   // A new result never follows straight on the acceptance of a word
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_accept))
      else $error("result too soon after input");

endmodule

bind langevin_two_axis_verlet_step ltv_check u_ltv_check (.*);

@@ test/tb_top.sv @@
// Self-checking bench for langevin_two_axis_verlet_step: drives noise words,
// mirrors the fixed-point Verlet update and compares every reported word.
// Depends on ltv_pkg and the stepper RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ltv_pkg::*;

   localparam int     DRAIN_CYCLES     = 64;
   localparam int     LONG_HOLD_CYCLES = 400;
   localparam longint WORD_MAX         = 64'sd2147483647;
   localparam longint WORD_MIN         = -64'sd2147483648;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam logic [WORD_W-1:0]    Q_ONE            = 32'h0001_0000;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_word_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_word_type         rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wdata = '0;

   // bench control
   bit source_gaps       = 1'b1;
   bit sink_gaps         = 1'b1;
   bit long_hold_pending = 1'b0;
   int error_count       = 0;

   // mirrored registers and integrator state, lane 0 is x, lane 1 is y
   bit [31:0]    lane_stiffness [2];
   bit [31:0]    mirror_damping, mirror_gain, mirror_dt;
   bit [15:0]    mirror_interval;
   bit [30:0]    mirror_limit;
   int           lane_pos [2];
   int           lane_vel [2];
   bit [31:0]    step_counter;
   bit           halted_seen;
   rsp_word_type expected_reports [$];

   langevin_two_axis_verlet_step dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("langevin_two_axis_verlet_step: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // exact product, magnitude rounded half away from zero, then shifted
   function automatic longint scaled_product(longint s, bit [31:0] u, int sh);
      bit [63:0] mag;
      longint    r;
      mag = (s < 0) ? 64'(-s) : 64'(s);
      r   = longint'((mag * 64'(u) + (64'd1 << (sh - 1))) >> sh);
      return (s < 0) ? -r : r;
   endfunction

   function automatic int clamp_word(longint v);
      if (v > WORD_MAX) return int'(WORD_MAX);
      if (v < WORD_MIN) return int'(WORD_MIN);
      return int'(v);
   endfunction

   // a = -k*p - gamma*v + f, summed exactly before saturation
   function automatic int lane_accel(int lane, int pos, int vel, int drive);
      return clamp_word(-scaled_product(pos, lane_stiffness[lane], 16)
                        - scaled_product(vel, mirror_damping, 16) + longint'(drive));
   endfunction

   // half kick, drift, half kick; dt*a uses a 17-bit shift for the half
   function automatic void lane_advance(int lane, int drive);
      int a;
      a = lane_accel(lane, lane_pos[lane], lane_vel[lane], drive);
      lane_vel[lane] = clamp_word(longint'(lane_vel[lane]) + scaled_product(a, mirror_dt, 17));
      lane_pos[lane] = clamp_word(longint'(lane_pos[lane])
                                  + scaled_product(lane_vel[lane], mirror_dt, 16));
      a = lane_accel(lane, lane_pos[lane], lane_vel[lane], drive);
      lane_vel[lane] = clamp_word(longint'(lane_vel[lane]) + scaled_product(a, mirror_dt, 17));
   endfunction

   function automatic void predict_step(req_word_type w);
      int           drive_x, drive_y;
      longint       reach_x;
      bit [31:0]    period;
      bit           went_lost;
      rsp_word_type due;
      // a halted block drops words silently
      if (halted_seen) return;
      drive_x = clamp_word(scaled_product(longint'($signed(w.noise_x)), mirror_gain, 12));
      drive_y = clamp_word(scaled_product(longint'($signed(w.noise_y)), mirror_gain, 12));
      lane_advance(0, drive_x);
      lane_advance(1, drive_y);
      reach_x   = (lane_pos[0] < 0) ? -longint'(lane_pos[0]) : longint'(lane_pos[0]);
      went_lost = reach_x > longint'(mirror_limit);
      // zero interval acts as one
      period    = (mirror_interval == 16'd0) ? 32'd1 : 32'(mirror_interval);
      if (went_lost || (step_counter % period) == 32'd0) begin
         due.step_number = step_counter;
         due.position_x  = lane_pos[0];
         due.position_y  = lane_pos[1];
         due.velocity_x  = lane_vel[0];
         due.velocity_y  = lane_vel[1];
         due.lost        = went_lost;
         expected_reports.push_back(due);
      end
      if (went_lost) halted_seen = 1'b1;
      step_counter = step_counter + 32'd1;
   endfunction

   function automatic void mirror_reset();
      lane_stiffness[0] = '0;
      lane_stiffness[1] = '0;
      mirror_damping    = '0;
      mirror_gain       = '0;
      mirror_dt         = '0;
      mirror_interval   = INTERVAL_RESET;
      mirror_limit      = LIMIT_RESET;
      lane_pos[0]       = 0;
      lane_pos[1]       = 0;
      lane_vel[0]       = 0;
      lane_vel[1]       = 0;
      step_counter      = STEP_RESET;
      halted_seen       = 1'b0;
   endfunction

   function automatic void mirror_write(logic [CSR_IDX_W-1:0] index, logic [WORD_W-1:0] value);
      case (index)
         CSR_STIFFNESS_X:  lane_stiffness[0] = value;
         CSR_STIFFNESS_Y:  lane_stiffness[1] = value;
         CSR_DAMPING_RATE: mirror_damping    = value;
         CSR_NOISE_GAIN:   mirror_gain       = value;
         CSR_TIME_STEP:    mirror_dt         = value;
         CSR_SAVE_INTVL:   mirror_interval   = value[INTERVAL_W-1:0];
         CSR_LOSS_LIMIT:   mirror_limit      = value[LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------ drive helpers

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
      error_count++;
   endtask

   // one register write, then the enable drops and the bus stays quiet before returning
   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [WORD_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mirror_write(index, value);
      @(posedge clock);
   endtask

   // offer one word, optionally after a short gap, and predict once taken
   task automatic send_word(req_word_type w);
      if (source_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_step(w);
   endtask

   // wait out every due report plus the pipeline depth
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_word_type make_word(logic [15:0] nx, logic [15:0] ny);
      req_word_type w;
      w.noise_x = nx;
      w.noise_y = ny;
      return w;
   endfunction

   // half moderate deviates, a quarter full-range, a quarter extremes
   function automatic logic [15:0] random_deviate();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2, 3:    return 16'($urandom);
         default: return 16'($urandom_range(0, 32767)) - 16'd16384;
      endcase
   endfunction

   task automatic send_random(int count);
      repeat (count) send_word(make_word(random_deviate(), random_deviate()));
   endtask

   // --------------------------------------------------------------- result side

   // receiver stall: one long hold on request, otherwise short random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each taken result word with the oldest due report
   always @(posedge clock) begin
      rsp_word_type due;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("result word with none due, step", rsp_data.step_number, '0);
         end else begin
            due = expected_reports.pop_front();
            if (rsp_data.step_number !== due.step_number)
               report_mismatch("step_number", rsp_data.step_number, due.step_number);
            if (rsp_data.position_x !== due.position_x)
               report_mismatch("position_x", rsp_data.position_x, due.position_x);
            if (rsp_data.position_y !== due.position_y)
               report_mismatch("position_y", rsp_data.position_y, due.position_y);
            if (rsp_data.velocity_x !== due.velocity_x)
               report_mismatch("velocity_x", rsp_data.velocity_x, due.velocity_x);
            if (rsp_data.velocity_y !== due.velocity_y)
               report_mismatch("velocity_y", rsp_data.velocity_y, due.velocity_y);
            if (rsp_data.lost !== due.lost)
               report_mismatch("lost", 32'(rsp_data.lost), 32'(due.lost));
         end
      end
   end

   // -------------------------------------------------------------------- tests

   // reset register values: nothing moves, every step reported
   task automatic test_reset_defaults();
      send_word(make_word(16'h8000, 16'h7FFF));
      send_word(make_word(16'h7FFF, 16'h8000));
      send_word(make_word(16'h0000, 16'h0000));
      send_word(make_word(16'hFFFF, 16'h0001));
      send_word(make_word(16'h0001, 16'hFFFF));
      send_word(make_word(16'h7FFF, 16'h7FFF));
      settle();
   endtask

   // every coefficient at its top with zero interval; x is still at rest and
   // gets no drive, so only y saturates
   task automatic test_saturation_extremes();
      write_csr(CSR_LOSS_LIMIT, 32'h7FFF_FFFF);
      write_csr(CSR_STIFFNESS_X, '1);
      write_csr(CSR_STIFFNESS_Y, '1);
      write_csr(CSR_DAMPING_RATE, '1);
      write_csr(CSR_NOISE_GAIN, '1);
      write_csr(CSR_TIME_STEP, '1);
      write_csr(CSR_SAVE_INTVL, '0);
      send_word(make_word(16'h0000, 16'h7FFF));
      send_word(make_word(16'h0000, 16'h8000));
      send_word(make_word(16'h0000, 16'h0001));
      send_word(make_word(16'h0000, 16'hFFFF));
      send_word(make_word(16'h0000, 16'h7FFF));
      send_word(make_word(16'h0000, 16'h7FFF));
      send_word(make_word(16'h0000, 16'h8000));
      send_word(make_word(16'h0000, random_deviate()));
      settle();
   endtask

   // reporting period, including one with no report at all
   task automatic test_save_interval();
      write_csr(CSR_STIFFNESS_X, Q_ONE);
      write_csr(CSR_STIFFNESS_Y, 2 * Q_ONE);
      write_csr(CSR_DAMPING_RATE, Q_ONE / 4);
      write_csr(CSR_NOISE_GAIN, Q_ONE);
      write_csr(CSR_TIME_STEP, Q_ONE / 16);
      write_csr(CSR_SAVE_INTVL, 32'd3);
      send_random(6);
      settle();
      write_csr(CSR_SAVE_INTVL, 32'd65535);
      send_random(5);
      settle();
   endtask

   // random settings per phase; x kept in a stable regime so it never escapes
   task automatic test_random_settings();
      for (int phase = 0; phase < 12; phase++) begin
         write_csr(CSR_STIFFNESS_X, $urandom_range(Q_ONE / 4, 4 * Q_ONE));
         case ($urandom_range(0, 3))
            0:       write_csr(CSR_STIFFNESS_Y, '0);
            1:       write_csr(CSR_STIFFNESS_Y, '1);
            default: write_csr(CSR_STIFFNESS_Y, $urandom_range(0, 8 * Q_ONE));
         endcase
         write_csr(CSR_DAMPING_RATE, $urandom_range(0, 2 * Q_ONE));
         write_csr(CSR_NOISE_GAIN, (phase == 0) ? '0 : $urandom_range(0, 4 * Q_ONE));
         write_csr(CSR_TIME_STEP, $urandom_range(0, Q_ONE / 8));
         // upper bits beyond each register's width must be dropped
         if (phase % 5 == 4)
            write_csr(CSR_SAVE_INTVL, {16'($urandom), 16'd16});
         else
            write_csr(CSR_SAVE_INTVL, {16'($urandom), 16'($urandom_range(0, 5))});
         write_csr(CSR_LOSS_LIMIT, {1'($urandom), 31'h7FFF_FFFF});
         write_csr(CSR_UNUSED_INDEX, $urandom);
         source_gaps = (phase % 4 != 3);
         sink_gaps   = (phase % 4 != 3);
         send_random(100);
         settle();
      end
      source_gaps = 1'b1;
      sink_gaps   = 1'b1;
   endtask

   // receiver holds off long enough for the block to back up its input
   task automatic test_backpressure();
      write_csr(CSR_SAVE_INTVL, 32'd1);
      long_hold_pending = 1'b1;
      send_random(40);
      settle();
   endtask

   // back-to-back words with no idling on either side
   task automatic test_quiet_tail();
      source_gaps = 1'b0;
      sink_gaps   = 1'b0;
      send_random(120);
      settle();
   endtask

   // loss ends the run: reported despite the period, then words are dropped
   task automatic test_loss_and_halt();
      write_csr(CSR_SAVE_INTVL, 32'd65535);
      write_csr(CSR_STIFFNESS_X, Q_ONE);
      write_csr(CSR_NOISE_GAIN, Q_ONE);
      write_csr(CSR_TIME_STEP, Q_ONE / 16);
      write_csr(CSR_LOSS_LIMIT, '0);
      send_word(make_word(16'h7FFF, random_deviate()));
      send_random(15);
      settle();
      // registers still take writes while halted
      write_csr(CSR_LOSS_LIMIT, 32'h7FFF_FFFF);
      write_csr(CSR_SAVE_INTVL, 32'd1);
      send_random(5);
      settle();
   endtask

   initial begin
      mirror_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_saturation_extremes();
      test_save_interval();
      test_random_settings();
      test_backpressure();
      test_quiet_tail();
      test_loss_and_halt();
      if (error_count == 0)
         $display("langevin_two_axis_verlet_step: match");
      else
         $display("langevin_two_axis_verlet_step: mismatch");
      $finish;
   end

endmodule

@@ langevin_two_axis_verlet_step.f @@
rtl/core/ltv_pkg.sv
rtl/core/ltv_lane.sv
rtl/core/ltv_rem.sv
rtl/core/langevin_two_axis_verlet_step.sv
rtl/core/ltv_check.sv
test/tb_top.sv
